// ----- sv/ccc_pkg.sv -----
// Calendar clock package: field widths, word layout and calendar helper functions.
package ccc_pkg;

  localparam int SecW   = 6;
  localparam int MinW   = 6;
  localparam int HourW  = 5;
  localparam int DayW   = 5;
  localparam int MonW   = 4;
  localparam int YearW  = 16;

  localparam int SetFieldW = 7;
  localparam int SetYearW  = 14;

  // input word: hold_ticks, then six set fields, padded to whole bytes
  localparam int InPackedW = 1 + 5 * SetFieldW + SetYearW;
  localparam int InDataW   = ((InPackedW + 7) / 8) * 8;
  // result word: six current fields, padded to whole bytes
  localparam int OutPackedW = SecW + MinW + HourW + DayW + MonW + YearW;
  localparam int OutDataW   = ((OutPackedW + 7) / 8) * 8;

  // what an input word asks for, carried on s_axis_tuser
  typedef enum logic {
    FuncTick = 1'b0,
    FuncSet  = 1'b1
  } func_e;

  localparam logic [6:0] SecondsPerMin = 7'd60;
  localparam logic [6:0] MinutesPerHour = 7'd60;
  localparam logic [5:0] HoursPerDay   = 6'd24;
  localparam logic [6:0] Months        = 7'd12;
  localparam logic [6:0] MaxSecond     = 7'd59;
  localparam logic [6:0] MaxMinute     = 7'd59;
  localparam logic [6:0] MaxHour       = 7'd23;
  localparam logic [6:0] February      = 7'd2;

  localparam logic [SecW-1:0]  ResetSeconds = '0;
  localparam logic [MinW-1:0]  ResetMinutes = '0;
  localparam logic [HourW-1:0] ResetHours   = '0;
  localparam logic [DayW-1:0]  ResetDay     = 5'd1;
  localparam logic [MonW-1:0]  ResetMonth   = 4'd1;
  localparam logic [YearW-1:0] ResetYear    = 16'd2000;

  // multiplicative inverse of 25 mod 2^16, and the largest product of a multiple of 25
  localparam logic [15:0] Inv25      = 16'd23593;
  localparam logic [15:0] Div25Limit = 16'd2621;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [4:0] LeapFebDays = 5'd29;

  // leap: divisible by 400 = by 16 and 25; by 100 = by 4 and 25
  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [15:0] p;
    logic        div25;
    p     = y * Inv25;
    div25 = (p <= Div25Limit);
    return div25 ? (y[3:0] == 4'd0) : (y[1:0] == 2'd0);
  endfunction

  // zero for a month outside 1..12
  function automatic logic [4:0] days_in(input logic [6:0] m, input logic [YearW-1:0] y);
    logic [4:0] d;
    logic [3:0] idx;
    d   = '0;
    idx = 4'(m - 7'd1);
    if (m >= 7'd1 && m <= Months) begin
      d = MONTH_LEN[idx];
      if (m == February && leap_year(y)) begin
        d = LeapFebDays;
      end
    end
    return d;
  endfunction

endpackage

// ----- sv/calendar_clock_counter.sv -----
// Calendar clock with Gregorian leap years: one word in, one result word out per word.
//
// Each input word is a one-second tick (tuser = 0) or a set request (tuser = 1).
// A word is registered on entry, then the carry chain and set validation run
// combinationally and update the date/time registers, which also serve as the result
// register. The result is valid once the registered word has been applied to those registers, and
// a new word is accepted every cycle while the result side keeps taking words. The clock
// resets to 00:00:00 on day 1 of month 1, year 2000. A rejected set leaves the
// clock unchanged and is flagged on m_axis_tuser.
module calendar_clock_counter
  import ccc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] hold_ticks, [7:1] set_seconds, [14:8] set_minutes, [21:15] set_hours,
  // [28:22] set_day, [35:29] set_month, [49:36] set_year, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] func: 0 tick, 1 set
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [5:0] cur_seconds, [11:6] cur_minutes, [16:12] cur_hours, [21:17] cur_day,
  // [25:22] cur_month, [41:26] cur_year, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] set_rejected
  output logic                m_axis_tuser
);

  typedef struct packed {
    func_e               func;
    logic                hold;
    logic [6:0]          sec;
    logic [6:0]          min;
    logic [6:0]          hour;
    logic [6:0]          day;
    logic [6:0]          mon;
    logic [SetYearW-1:0] year;
  } item_t;

  logic       in_valid;
  item_t      in_item;
  logic       advance;

  logic [SecW-1:0]  seconds, seconds_next;
  logic [MinW-1:0]  minutes, minutes_next;
  logic [HourW-1:0] hours, hours_next;
  logic [DayW-1:0]  day, day_next;
  logic [MonW-1:0]  month, month_next;
  logic [YearW-1:0] year, year_next;
  logic             rejected, rejected_next;
  logic             out_valid;

  logic [6:0] sec_inc, min_inc, mon_inc;
  logic [5:0] hour_inc, day_inc;
  logic [4:0] cur_days, set_days;
  logic       set_ok;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.func <= func_e'(s_axis_tuser);
      in_item.hold <= s_axis_tdata[0];
      in_item.sec  <= s_axis_tdata[7:1];
      in_item.min  <= s_axis_tdata[14:8];
      in_item.hour <= s_axis_tdata[21:15];
      in_item.day  <= s_axis_tdata[28:22];
      in_item.mon  <= s_axis_tdata[35:29];
      in_item.year <= s_axis_tdata[49:36];
    end
  end

  assign sec_inc  = 7'(seconds) + 7'd1;
  assign min_inc  = 7'(minutes) + 7'd1;
  assign hour_inc = 6'(hours) + 6'd1;
  assign day_inc  = 6'(day) + 6'd1;
  assign mon_inc  = 7'(month) + 7'd1;
  assign cur_days = days_in(7'(month), year);
  assign set_days = days_in(in_item.mon, 16'(in_item.year));

  assign set_ok = in_item.sec <= MaxSecond && in_item.min <= MaxMinute &&
                  in_item.hour <= MaxHour && in_item.mon >= 7'd1 &&
                  in_item.mon <= Months && in_item.day >= 7'd1 &&
                  in_item.day <= 7'(set_days);

  always_comb begin
    seconds_next  = seconds;
    minutes_next  = minutes;
    hours_next    = hours;
    day_next      = day;
    month_next    = month;
    year_next     = year;
    rejected_next = 1'b0;
    if (in_item.func == FuncSet) begin
      if (set_ok) begin
        seconds_next = in_item.sec[SecW-1:0];
        minutes_next = in_item.min[MinW-1:0];
        hours_next   = in_item.hour[HourW-1:0];
        day_next     = in_item.day[DayW-1:0];
        month_next   = in_item.mon[MonW-1:0];
        year_next    = 16'(in_item.year);
      end else begin
        rejected_next = 1'b1;
      end
    end else if (!in_item.hold) begin
      // ripple of carries: each unit only rolls when the one below wrapped
      if (sec_inc < SecondsPerMin) begin
        seconds_next = sec_inc[SecW-1:0];
      end else begin
        seconds_next = '0;
        if (min_inc < MinutesPerHour) begin
          minutes_next = min_inc[MinW-1:0];
        end else begin
          minutes_next = '0;
          if (hour_inc < HoursPerDay) begin
            hours_next = hour_inc[HourW-1:0];
          end else begin
            hours_next = '0;
            if (day_inc <= 6'(cur_days)) begin
              day_next = day_inc[DayW-1:0];
            end else begin
              day_next = 5'd1;
              if (mon_inc > Months) begin
                month_next = 4'd1;
                year_next  = year + 16'd1;
              end else begin
                month_next = mon_inc[MonW-1:0];
              end
            end
          end
        end
      end
    end
  end

  // the date/time registers double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds   <= ResetSeconds;
      minutes   <= ResetMinutes;
      hours     <= ResetHours;
      day       <= ResetDay;
      month     <= ResetMonth;
      year      <= ResetYear;
      rejected  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        seconds  <= seconds_next;
        minutes  <= minutes_next;
        hours    <= hours_next;
        day      <= day_next;
        month    <= month_next;
        year     <= year_next;
        rejected <= rejected_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = rejected;
  assign m_axis_tdata  = {(OutDataW - OutPackedW)'(0), year, month, day, hours, minutes, seconds};

endmodule

// ----- sv/ccc_checker.sv -----
// Port-level checker for the calendar clock, bound to the top level.
module ccc_checker
  import ccc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with result side empty");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[5:0] <= 6'd59 && m_axis_tdata[11:6] <= 6'd59 &&
      m_axis_tdata[16:12] <= 5'd23 && m_axis_tdata[21:17] >= 5'd1 &&
      m_axis_tdata[25:22] >= 4'd1 && m_axis_tdata[25:22] <= 4'd12)
    else $error("date/time field out of range");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (.*);
